[hdl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg - shared types and lexing functions
// Token codes, keyword table, scanner context and the per-byte scan step.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned OFFSET_BITS   = 24;
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned QAW           = 2;
  localparam int unsigned QCW           = 3;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [OFFSET_BITS-1:0]   OFF_MAX = '1;
  localparam logic [15:0]              LEN_MAX = '1;

  localparam logic [5:0] K_EOF     = 6'd0;
  localparam logic [5:0] K_NEWLINE = 6'd1;
  localparam logic [5:0] K_SEMI    = 6'd2;
  localparam logic [5:0] K_LBRACK  = 6'd3;
  localparam logic [5:0] K_RBRACK  = 6'd4;
  localparam logic [5:0] K_LPAREN  = 6'd5;
  localparam logic [5:0] K_RPAREN  = 6'd6;
  localparam logic [5:0] K_LBRACE  = 6'd7;
  localparam logic [5:0] K_RBRACE  = 6'd8;
  localparam logic [5:0] K_ANGLE_O = 6'd9;
  localparam logic [5:0] K_DOTDOT  = 6'd10;
  localparam logic [5:0] K_PLUS    = 6'd11;
  localparam logic [5:0] K_MINUS   = 6'd12;
  localparam logic [5:0] K_STAR    = 6'd13;
  localparam logic [5:0] K_SLASH   = 6'd14;
  localparam logic [5:0] K_PCT     = 6'd15;
  localparam logic [5:0] K_CARET   = 6'd16;
  localparam logic [5:0] K_ASSIGN  = 6'd17;
  localparam logic [5:0] K_EQ      = 6'd18;
  localparam logic [5:0] K_NE      = 6'd19;
  localparam logic [5:0] K_LE      = 6'd20;
  localparam logic [5:0] K_GE      = 6'd21;
  localparam logic [5:0] K_ADDEQ   = 6'd22;
  localparam logic [5:0] K_SUBEQ   = 6'd23;
  localparam logic [5:0] K_MULEQ   = 6'd24;
  localparam logic [5:0] K_DIVEQ   = 6'd25;
  localparam logic [5:0] K_MODEQ   = 6'd26;
  localparam logic [5:0] K_ANDAND  = 6'd27;
  localparam logic [5:0] K_OROR    = 6'd28;
  localparam logic [5:0] K_BANG    = 6'd29;
  localparam logic [5:0] K_AMP     = 6'd30;
  localparam logic [5:0] K_PIPE    = 6'd31;
  localparam logic [5:0] K_TILDE   = 6'd32;
  localparam logic [5:0] K_SHL     = 6'd33;
  localparam logic [5:0] K_SHR     = 6'd34;
  localparam logic [5:0] K_LT      = 6'd35;
  localparam logic [5:0] K_GT      = 6'd36;
  localparam logic [5:0] K_COMMA   = 6'd37;
  localparam logic [5:0] K_QUEST   = 6'd38;
  localparam logic [5:0] K_KW0     = 6'd39;
  localparam logic [5:0] K_IDENT   = 6'd54;
  localparam logic [5:0] K_INT     = 6'd55;
  localparam logic [5:0] K_FLOAT   = 6'd56;
  localparam logic [5:0] K_STRING  = 6'd57;
  localparam logic [5:0] K_SBYTE   = 6'd58;
  localparam logic [5:0] K_ERROR   = 6'd59;

  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_CHAR  = 2'd1;
  localparam logic [1:0] E_UNTERM = 2'd2;

  localparam int unsigned NKW = 15;
  // Keywords left aligned in seven characters; padding is never compared.
  localparam logic [55:0] KW_STR [NKW] = '{
    "return ", "stop   ", "next   ", "raise  ", "print  ", "the    ", "if     ",
    "else   ", "elif   ", "when   ", "for    ", "in     ", "true   ", "false  ",
    "nil    "};
  localparam logic [2:0] KW_LEN [NKW] = '{
    3'd6, 3'd4, 3'd4, 3'd5, 3'd5, 3'd3, 3'd2, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd4,
    3'd5, 3'd3};

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_INT, M_INT_DOT, M_FRAC, M_OP, M_STR, M_ESC,
    M_HEX0, M_HEX1
  } mode_e;

  typedef struct packed {
    logic [5:0]               kind;
    logic [POSITION_BITS-1:0] line;
    logic [POSITION_BITS-1:0] col;
    logic [63:0]              num;
    logic [7:0]               frac;
    logic [7:0]               schar;
    logic [OFFSET_BITS-1:0]   off;
    logic [15:0]              len;
    logic [1:0]               err;
  } tok_t;

  // Results caused by one input byte, front to back.
  typedef struct packed {
    logic [1:0]       n;
    tok_t [2:0]       r;
  } bnd_t;

  typedef struct packed {
    mode_e                    mode;
    logic [7:0]               pend;
    logic [7:0]               hexd;
    logic [POSITION_BITS-1:0] lc;
    logic [POSITION_BITS-1:0] cc;
    logic [POSITION_BITS-1:0] sl;
    logic [POSITION_BITS-1:0] sc;
    logic [POSITION_BITS-1:0] dc;
    logic [OFFSET_BITS-1:0]   boff;
    logic [OFFSET_BITS-1:0]   toff;
    logic [15:0]              ilen;
    logic [NKW-1:0]           kwc;
    logic [63:0]              acc;
    logic [7:0]               frac;
    logic                     ss;
    logic                     halt;
    logic [POSITION_BITS-1:0] curl;
    logic [POSITION_BITS-1:0] curc;
    logic [OFFSET_BITS-1:0]   curo;
    bnd_t                     b;
  } ctx_t;

  function automatic ctx_t rst_ctx();
    ctx_t c;
    c      = '0;
    c.mode = M_IDLE;
    c.lc   = POSITION_BITS'(1);
    c.cc   = POSITION_BITS'(1);
    c.sl   = POSITION_BITS'(1);
    c.sc   = POSITION_BITS'(1);
    c.dc   = POSITION_BITS'(1);
    c.curl = POSITION_BITS'(1);
    c.curc = POSITION_BITS'(1);
    c.kwc  = '1;
    c.ss   = 1'b1;
    return c;
  endfunction

  function automatic logic [POSITION_BITS-1:0] sat_pos(logic [POSITION_BITS-1:0] v);
    return (v < POS_MAX) ? v + 1'b1 : POS_MAX;
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction

  function automatic logic is_hex(logic [7:0] ch);
    return is_digit(ch) || (ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F");
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] ch);
    logic [7:0] l;
    l = ch | 8'h20;
    return is_digit(ch) ? 4'(ch - "0") : 4'(l - "a" + 8'd10);
  endfunction

  function automatic tok_t mk(logic [5:0] kind, logic [POSITION_BITS-1:0] line,
                              logic [POSITION_BITS-1:0] col);
    tok_t t;
    t      = '0;
    t.kind = kind;
    t.line = line;
    t.col  = col;
    return t;
  endfunction

  // A fourth result overwrites the third.
  function automatic ctx_t emit(ctx_t c, tok_t t);
    logic [1:0] s;
    s = (c.b.n == 2'd3) ? 2'd2 : c.b.n;
    c.b.r[s] = t;
    c.b.n    = s + 2'd1;
    if (t.kind < K_SBYTE) c.ss = (t.kind == K_NEWLINE) || (t.kind == K_SEMI);
    return c;
  endfunction

  function automatic ctx_t fail(ctx_t c, logic [1:0] code, logic [POSITION_BITS-1:0] line,
                                logic [POSITION_BITS-1:0] col, logic [7:0] ch);
    tok_t t;
    t       = mk(K_ERROR, line, col);
    t.schar = ch;
    t.err   = code;
    c       = emit(c, t);
    c.halt  = 1'b1;
    c.mode  = M_IDLE;
    return c;
  endfunction

  function automatic ctx_t str_byte(ctx_t c, logic [7:0] ch);
    tok_t t;
    t       = mk(K_SBYTE, c.curl, c.curc);
    t.schar = ch;
    return emit(c, t);
  endfunction

  function automatic ctx_t kw_filter(ctx_t c, logic [7:0] ch);
    logic [7:0] kc;
    for (int k = 0; k < NKW; k++) begin
      kc = KW_STR[k][55 - 8*int'(c.ilen[2:0]) -: 8];
      if (c.ilen >= 16'(KW_LEN[k]) || kc != ch) c.kwc[k] = 1'b0;
    end
    if (c.ilen < LEN_MAX) c.ilen = c.ilen + 16'd1;
    return c;
  endfunction

  function automatic ctx_t emit_ident(ctx_t c);
    tok_t       t;
    logic [5:0] kind;
    kind = K_IDENT;
    for (int k = 0; k < NKW; k++) begin
      if (c.kwc[k] && 16'(KW_LEN[k]) == c.ilen) kind = K_KW0 + 6'(k);
    end
    t     = mk(kind, c.sl, c.sc);
    t.off = c.toff;
    t.len = c.ilen;
    return emit(c, t);
  endfunction

  function automatic ctx_t emit_number(ctx_t c, logic [5:0] kind);
    tok_t t;
    t      = mk(kind, c.sl, c.sc);
    t.num  = c.acc;
    t.frac = (kind == K_FLOAT) ? c.frac : 8'd0;
    return emit(c, t);
  endfunction

  function automatic logic [63:0] mac10(logic [63:0] a, logic [7:0] ch);
    return (a << 3) + (a << 1) + 64'(ch - "0");
  endfunction

  function automatic ctx_t op_single(ctx_t c);
    logic [5:0] k;
    logic       ok;
    c.mode = M_IDLE;
    ok     = 1'b1;
    k      = K_EOF;
    case (c.pend)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "%":     k = K_PCT;
      "=":     k = K_ASSIGN;
      "!":     k = K_BANG;
      "&":     k = K_AMP;
      "|":     k = K_PIPE;
      "<":     k = c.ss ? K_ANGLE_O : K_LT;
      ">":     k = K_GT;
      default: ok = 1'b0;
    endcase
    if (ok) c = emit(c, mk(k, c.sl, c.sc));
    else    c = fail(c, E_CHAR, c.sl, c.sc, c.pend);
    return c;
  endfunction

  function automatic logic [5:0] pair_kind(logic [7:0] a, logic [7:0] b);
    logic [5:0] k;
    k = K_EOF;
    if (b == "=") begin
      case (a)
        "=":     k = K_EQ;
        "!":     k = K_NE;
        "<":     k = K_LE;
        ">":     k = K_GE;
        "+":     k = K_ADDEQ;
        "-":     k = K_SUBEQ;
        "*":     k = K_MULEQ;
        "/":     k = K_DIVEQ;
        "%":     k = K_MODEQ;
        default: k = K_EOF;
      endcase
    end else if (a == b) begin
      case (a)
        "&":     k = K_ANDAND;
        "|":     k = K_OROR;
        "<":     k = K_SHL;
        ">":     k = K_SHR;
        ".":     k = K_DOTDOT;
        default: k = K_EOF;
      endcase
    end
    return k;
  endfunction

  function automatic ctx_t lead(ctx_t c, logic [7:0] ch);
    logic [5:0] k;
    logic       one;
    c.mode = M_IDLE;
    k      = K_EOF;
    one    = 1'b0;
    if (ch == " " || ch == 8'h09 || ch == 8'h0d) begin
      return c;
    end
    if (ch == 8'h0a) return emit(c, mk(K_NEWLINE, sat_pos(c.curl), POSITION_BITS'(1)));
    if (ch == "#") begin
      c.mode = M_COMMENT;
      return c;
    end
    c.sl = c.curl;
    c.sc = c.curc;
    if (ch == 8'h22) begin
      c      = emit(c, mk(K_STRING, c.curl, c.curc));
      c.mode = M_STR;
    end else if (is_digit(ch)) begin
      c.acc  = 64'(ch - "0");
      c.frac = 8'd0;
      c.mode = M_INT;
    end else if (is_alpha(ch) || ch == "_") begin
      c.toff = c.curo;
      c.ilen = 16'd0;
      c.kwc  = '1;
      c      = kw_filter(c, ch);
      c.mode = M_IDENT;
    end else begin
      case (ch)
        "+", "-", "*", "/", "%", "=", "!", "&", "|", "<", ">", ".": begin
          c.pend = ch;
          c.mode = M_OP;
        end
        ";":     begin k = K_SEMI;   one = 1'b1; end
        "[":     begin k = K_LBRACK; one = 1'b1; end
        "]":     begin k = K_RBRACK; one = 1'b1; end
        "(":     begin k = K_LPAREN; one = 1'b1; end
        ")":     begin k = K_RPAREN; one = 1'b1; end
        "{":     begin k = K_LBRACE; one = 1'b1; end
        "}":     begin k = K_RBRACE; one = 1'b1; end
        "^":     begin k = K_CARET;  one = 1'b1; end
        "~":     begin k = K_TILDE;  one = 1'b1; end
        ",":     begin k = K_COMMA;  one = 1'b1; end
        "?":     begin k = K_QUEST;  one = 1'b1; end
        default: c = fail(c, E_CHAR, c.curl, c.curc, ch);
      endcase
      if (one) c = emit(c, mk(k, c.curl, c.curc));
    end
    return c;
  endfunction

  function automatic ctx_t op_second(ctx_t c, logic [7:0] ch);
    logic [5:0] k;
    k = pair_kind(c.pend, ch);
    if (k != K_EOF) begin
      c      = emit(c, mk(k, c.sl, c.sc));
      c.mode = M_IDLE;
    end else begin
      c = op_single(c);
      if (!c.halt) c = lead(c, ch);
    end
    return c;
  endfunction

  function automatic ctx_t str_plain(ctx_t c, logic [7:0] ch);
    c.mode = M_STR;
    if (ch == 8'h22)      c.mode = M_IDLE;
    else if (ch == "\\")  c.mode = M_ESC;
    else                  c = str_byte(c, ch);
    return c;
  endfunction

  function automatic ctx_t feed(ctx_t c, logic [7:0] ch);
    logic w;
    w = is_alpha(ch) || is_digit(ch) || ch == "_";
    unique case (c.mode)
      M_COMMENT: if (ch == 8'h0a) c = lead(c, ch);
      M_IDENT: begin
        if (w) c = kw_filter(c, ch);
        else c = lead(emit_ident(c), ch);
      end
      M_INT: begin
        if (is_digit(ch)) c.acc = mac10(c.acc, ch);
        else if (ch == ".") begin
          c.dc   = c.curc;
          c.mode = M_INT_DOT;
        end else c = lead(emit_number(c, K_INT), ch);
      end
      M_INT_DOT: begin
        if (is_digit(ch)) begin
          c.acc  = mac10(c.acc, ch);
          c.frac = 8'd1;
          c.mode = M_FRAC;
        end else begin
          c      = emit_number(c, K_INT);
          c.pend = ".";
          c.sc   = c.dc;
          c.mode = M_OP;
          c      = op_second(c, ch);
        end
      end
      M_FRAC: begin
        if (is_digit(ch)) begin
          c.acc = mac10(c.acc, ch);
          if (c.frac != 8'hff) c.frac = c.frac + 8'd1;
        end else c = lead(emit_number(c, K_FLOAT), ch);
      end
      M_OP:  c = op_second(c, ch);
      M_STR: c = str_plain(c, ch);
      M_ESC: begin
        c.mode = M_STR;
        case (ch)
          "n":     c = str_byte(c, 8'h0a);
          "t":     c = str_byte(c, 8'h09);
          "r":     c = str_byte(c, 8'h0d);
          "0":     c = str_byte(c, 8'h00);
          "x":     c.mode = M_HEX0;
          default: c = str_byte(c, ch);
        endcase
      end
      M_HEX0: begin
        if (is_hex(ch)) begin
          c.hexd = ch;
          c.mode = M_HEX1;
        end else c = str_plain(str_byte(c, "x"), ch);
      end
      M_HEX1: begin
        if (is_hex(ch)) begin
          c      = str_byte(c, {hex_val(c.hexd), hex_val(ch)});
          c.mode = M_STR;
        end else c = str_plain(str_byte(str_byte(c, "x"), c.hexd), ch);
      end
      default: c = lead(c, ch);
    endcase
    return c;
  endfunction

  function automatic ctx_t finish(ctx_t c);
    unique case (c.mode)
      M_IDENT:   c = emit_ident(c);
      M_INT:     c = emit_number(c, K_INT);
      M_INT_DOT: c = fail(emit_number(c, K_INT), E_CHAR, c.sl, c.dc, ".");
      M_FRAC:    c = emit_number(c, K_FLOAT);
      M_OP:      c = op_single(c);
      M_STR, M_ESC, M_HEX0, M_HEX1: c = fail(c, E_UNTERM, c.sl, c.sc, 8'd0);
      default:   c = c;
    endcase
    if (!c.halt) c = emit(c, mk(K_EOF, c.lc, c.cc));
    return c;
  endfunction

endpackage

[hdl/stt_intf.sv]
// ----------------------------------------------------------------------------
// stt_intf - channel interfaces
// Source byte channel and token result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;
  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink   (input valid, source_byte, end_of_source, output ready);
endinterface

interface stt_tok_if;
  logic                             valid;
  logic                             ready;
  logic [5:0]                       lexeme_kind;
  logic [stt_pkg::POSITION_BITS-1:0] token_line;
  logic [stt_pkg::POSITION_BITS-1:0] token_column;
  logic [63:0]                      number_value;
  logic [7:0]                       fraction_digits;
  logic [7:0]                       string_char;
  logic [stt_pkg::OFFSET_BITS-1:0]  span_offset;
  logic [15:0]                      span_length;
  logic [1:0]                       error_code;
  logic                             last_of_step;
  modport source (output valid, lexeme_kind, token_line, token_column, number_value,
                  fraction_digits, string_char, span_offset, span_length, error_code,
                  last_of_step, input ready);
  modport sink   (input valid, lexeme_kind, token_line, token_column, number_value,
                  fraction_digits, string_char, span_offset, span_length, error_code,
                  last_of_step, output ready);
endinterface

[hdl/source_text_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit - streaming lexer, one source byte per cycle
// Top level: scanner front, result queue and output back end.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i carries one source byte per transaction; end_of_source marks the
//   last byte, and a zero byte also ends the source without being lexed.
//   tok_o carries one token per transaction; last_of_step flags the final
//   token caused by an input byte (a byte causes zero to three tokens).
//   A byte's bundle is written into the queue at the edge that takes the
//   byte; the output register is then loaded from the queue head and the
//   token offered on tok_o, later if tokens are queued ahead of it.
//   Throughput: one byte per cycle while the output keeps up; output is
//   one token per cycle, so bytes yielding several tokens back-pressure
//   the input through a four-bundle queue.
//   Reset (asynchronous, active low) puts the scanner at line 1, column 1,
//   empties the queue and drops any token held at the output.
//   A stall on tok_o holds the token in place; the scanner keeps taking
//   bytes until the queue fills, then drops byte_i.ready.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_byte_if.sink  byte_i,
  stt_tok_if.source tok_o
);

  // Bundle handoff between scanner and queue.
  logic          bnd_valid;
  logic          bnd_ready;
  stt_pkg::bnd_t bnd;

  // Scanner: all lexing state, decides every byte in its own cycle.
  stt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .bnd_ready_i (bnd_ready),
    .bnd_valid_o (bnd_valid),
    .bnd_o       (bnd)
  );

  // Queue and serialiser: one token per output transaction.
  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bnd_valid_i (bnd_valid),
    .bnd_i       (bnd),
    .bnd_ready_o (bnd_ready),
    .tok_o       (tok_o)
  );

endmodule

[hdl/stt_front.sv]
// ----------------------------------------------------------------------------
// stt_front - byte scanner
// One byte per cycle unless stalled: updates scan state, pushes result bundle.
// ----------------------------------------------------------------------------
module stt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  stt_byte_if.sink      byte_i,
  input  logic          bnd_ready_i,
  output logic          bnd_valid_o,
  output stt_pkg::bnd_t bnd_o
);

  stt_pkg::ctx_t st_q, st_d, w;
  logic          acc_byte;
  logic          ends;

  assign byte_i.ready = bnd_ready_i;
  assign acc_byte     = byte_i.valid && bnd_ready_i;
  assign ends         = byte_i.end_of_source || (byte_i.source_byte == 8'd0);

  always_comb begin
    w      = st_q;
    w.b    = '0;
    if (!st_q.halt && byte_i.source_byte != 8'd0) begin
      w.curl = st_q.lc;
      w.curc = st_q.cc;
      w.curo = st_q.boff;
      w      = stt_pkg::feed(w, byte_i.source_byte);
      if (w.boff < stt_pkg::OFF_MAX) w.boff = w.boff + 1'b1;
      if (byte_i.source_byte == 8'h0a && st_q.mode != stt_pkg::M_ESC) begin
        w.lc = stt_pkg::sat_pos(w.lc);
        w.cc = stt_pkg::POSITION_BITS'(1);
      end else begin
        w.cc = stt_pkg::sat_pos(w.cc);
      end
    end
    if (ends && !st_q.halt) w = stt_pkg::finish(w);
    st_d = ends ? stt_pkg::rst_ctx() : w;
    st_d.b = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= stt_pkg::rst_ctx();
    end else if (acc_byte) begin
      st_q <= st_d;
    end
  end

  assign bnd_valid_o = acc_byte && (w.b.n != 2'd0);
  assign bnd_o       = w.b;

`ifndef NO_ASSERTIONS
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_byte && st_q.halt) |-> !bnd_valid_o)
    else $error("halted scanner produced results");
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_byte && ends) |=> (st_q.mode == stt_pkg::M_IDLE && !st_q.halt))
    else $error("scanner not back to idle after end of source");
`endif

endmodule

[hdl/stt_back.sv]
// ----------------------------------------------------------------------------
// stt_back - result queue and output stage
// Queues result bundles and hands out one token per transaction.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          bnd_valid_i,
  input  stt_pkg::bnd_t bnd_i,
  output logic          bnd_ready_o,
  stt_tok_if.source     tok_o
);

  stt_pkg::bnd_t                q_mem [stt_pkg::QDEPTH];
  logic [stt_pkg::QAW-1:0]      wp_q, rp_q;
  logic [stt_pkg::QCW-1:0]      cnt_q;
  logic [1:0]                   sub_q;
  logic                         ov_q, last_q;
  stt_pkg::tok_t                tok_q;
  stt_pkg::bnd_t                head;
  logic                         load, pop, head_v, is_last;

  assign head        = q_mem[rp_q];
  assign head_v      = cnt_q != '0;
  assign bnd_ready_o = cnt_q < stt_pkg::QCW'(stt_pkg::QDEPTH);
  assign load        = head_v && (!ov_q || tok_o.ready);
  assign is_last     = sub_q == (head.n - 2'd1);
  assign pop         = load && is_last;

  always_ff @(posedge clk_i) begin
    if (bnd_valid_i) q_mem[wp_q] <= bnd_i;
    if (load) begin
      tok_q  <= head.r[sub_q];
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
      sub_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (bnd_valid_i) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + stt_pkg::QCW'(bnd_valid_i) - stt_pkg::QCW'(pop);
      if (load) sub_q <= is_last ? 2'd0 : sub_q + 2'd1;
      if (load) ov_q <= 1'b1;
      else if (tok_o.ready) ov_q <= 1'b0;
    end
  end

  assign tok_o.valid           = ov_q;
  assign tok_o.lexeme_kind     = tok_q.kind;
  assign tok_o.token_line      = tok_q.line;
  assign tok_o.token_column    = tok_q.col;
  assign tok_o.number_value    = tok_q.num;
  assign tok_o.fraction_digits = tok_q.frac;
  assign tok_o.string_char     = tok_q.schar;
  assign tok_o.span_offset     = tok_q.off;
  assign tok_o.span_length     = tok_q.len;
  assign tok_o.error_code      = tok_q.err;
  assign tok_o.last_of_step    = last_q;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bnd_valid_i |-> (cnt_q < stt_pkg::QCW'(stt_pkg::QDEPTH)))
    else $error("result queue overflow");
  a_bundle_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bnd_valid_i |-> (bnd_i.n != 2'd0))
    else $error("empty bundle pushed");
  a_sub_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_v |-> (sub_q < head.n))
    else $error("result index beyond bundle");
`endif

endmodule

[verif/source_text_tokenizer_unit_test.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit_test - self-checking bench for the source lexer
// Feeds whole source texts byte by byte, directed then random, with random
// gaps on the byte side and random stalls on the token side. Every byte taken
// runs through a lexer model kept in the bench; every token given out is
// checked field by field against the oldest predicted token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module source_text_tokenizer_unit_test;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_WAIT  = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  stt_byte_if byte_ch ();
  stt_tok_if  tok_ch ();

  source_text_tokenizer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch),
    .tok_o  (tok_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One byte transaction waiting to go; rush items are sent without gaps.
  typedef struct {
    logic [7:0] b;
    logic       eos;
    bit         rush;
  } src_item_t;

  typedef struct {
    stt_pkg::tok_t t;
    logic          last;
  } tok_exp_t;

  src_item_t src_items[$];
  tok_exp_t  tokens_due[$];
  logic [7:0] frag[$];

  int unsigned errors      = 0;
  int unsigned bytes_taken = 0;
  int unsigned toks_seen   = 0;
  int unsigned cycles      = 0;
  bit          took_byte   = 1'b0;
  bit          took_tok    = 1'b0;

  // --------------------------------------------------------------------------
  // Lexer model state
  // --------------------------------------------------------------------------
  stt_pkg::mode_e scan;
  logic [7:0]  held_op, hex_hi;
  logic [15:0] line_no, col_no, tok_line, tok_col, dot_col;
  logic [15:0] here_line, here_col;
  logic [23:0] src_off, word_off, here_off;
  logic [15:0] word_len;
  string       word_txt;
  logic [63:0] acc_val;
  logic [7:0]  frac_cnt;
  bit          at_stmt, halted;
  stt_pkg::tok_t step_out[3];
  int          step_n;

  string kw_list[15] = '{"return", "stop", "next", "raise", "print", "the", "if",
                         "else", "elif", "when", "for", "in", "true", "false", "nil"};

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic bit dig(logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic bit alpha(logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction

  function automatic bit hexc(logic [7:0] ch);
    return dig(ch) || (ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F");
  endfunction

  function automatic logic [3:0] nibble(logic [7:0] ch);
    if (dig(ch)) return 4'(ch - "0");
    return 4'((ch | 8'h20) - "a" + 8'd10);
  endfunction

  task automatic clear_lexer();
    scan     = stt_pkg::M_IDLE;
    held_op  = '0;
    hex_hi   = '0;
    line_no  = 16'd1;
    col_no   = 16'd1;
    tok_line = 16'd1;
    tok_col  = 16'd1;
    dot_col  = 16'd1;
    src_off  = '0;
    word_off = '0;
    word_len = '0;
    word_txt = "";
    acc_val  = '0;
    frac_cnt = '0;
    at_stmt  = 1'b1;
    halted   = 1'b0;
  endtask

  // Appends a token; a fourth one in a step lands on the third slot.
  task automatic put(logic [5:0] k, logic [15:0] l, logic [15:0] c);
    int i;
    i = (step_n == 3) ? 2 : step_n;
    step_out[i]      = '0;
    step_out[i].kind = k;
    step_out[i].line = l;
    step_out[i].col  = c;
    step_n           = i + 1;
    if (k < stt_pkg::K_SBYTE)
      at_stmt = (k == stt_pkg::K_NEWLINE) || (k == stt_pkg::K_SEMI);
  endtask

  task automatic stop_on(logic [1:0] code, logic [15:0] l, logic [15:0] c, logic [7:0] ch);
    put(stt_pkg::K_ERROR, l, c);
    step_out[step_n-1].schar = ch;
    step_out[step_n-1].err   = code;
    halted = 1'b1;
    scan   = stt_pkg::M_IDLE;
  endtask

  task automatic sbyte(logic [7:0] ch);
    put(stt_pkg::K_SBYTE, here_line, here_col);
    step_out[step_n-1].schar = ch;
  endtask

  task automatic grow_word(logic [7:0] ch);
    if (word_len < 16'd8) word_txt = {word_txt, string'(ch)};
    if (word_len != 16'hffff) word_len = word_len + 16'd1;
  endtask

  task automatic give_word();
    logic [5:0] k;
    k = stt_pkg::K_IDENT;
    for (int i = 0; i < 15; i++)
      if (word_txt == kw_list[i] && word_len == 16'(kw_list[i].len()))
        k = stt_pkg::K_KW0 + 6'(i);
    put(k, tok_line, tok_col);
    step_out[step_n-1].off = word_off;
    step_out[step_n-1].len = word_len;
  endtask

  task automatic give_num(logic [5:0] k);
    put(k, tok_line, tok_col);
    step_out[step_n-1].num  = acc_val;
    step_out[step_n-1].frac = (k == stt_pkg::K_FLOAT) ? frac_cnt : 8'd0;
  endtask

  // Held operator char with no partner; only a lone dot is an error.
  task automatic lone_op(output bit ok);
    logic [5:0] k;
    scan = stt_pkg::M_IDLE;
    ok   = 1'b1;
    k    = stt_pkg::K_EOF;
    case (held_op)
      "+": k = stt_pkg::K_PLUS;
      "-": k = stt_pkg::K_MINUS;
      "*": k = stt_pkg::K_STAR;
      "/": k = stt_pkg::K_SLASH;
      "%": k = stt_pkg::K_PCT;
      "=": k = stt_pkg::K_ASSIGN;
      "!": k = stt_pkg::K_BANG;
      "&": k = stt_pkg::K_AMP;
      "|": k = stt_pkg::K_PIPE;
      "<": k = at_stmt ? stt_pkg::K_ANGLE_O : stt_pkg::K_LT;
      ">": k = stt_pkg::K_GT;
      default: ok = 1'b0;
    endcase
    if (ok) put(k, tok_line, tok_col);
    else stop_on(stt_pkg::E_CHAR, tok_line, tok_col, held_op);
  endtask

  task automatic start_tok(logic [7:0] ch);
    logic [5:0] k;
    scan = stt_pkg::M_IDLE;
    k    = stt_pkg::K_EOF;
    if (ch == " " || ch == 8'h09 || ch == 8'h0d) return;
    if (ch == 8'h0a) begin
      put(stt_pkg::K_NEWLINE, bump(here_line), 16'd1);
      return;
    end
    if (ch == "#") begin
      scan = stt_pkg::M_COMMENT;
      return;
    end
    tok_line = here_line;
    tok_col  = here_col;
    if (ch == 8'h22) begin
      put(stt_pkg::K_STRING, here_line, here_col);
      scan = stt_pkg::M_STR;
      return;
    end
    if (dig(ch)) begin
      acc_val  = 64'(ch - "0");
      frac_cnt = 8'd0;
      scan     = stt_pkg::M_INT;
      return;
    end
    if (alpha(ch) || ch == "_") begin
      word_off = here_off;
      word_len = 16'd0;
      word_txt = "";
      grow_word(ch);
      scan = stt_pkg::M_IDENT;
      return;
    end
    case (ch)
      "+", "-", "*", "/", "%", "=", "!", "&", "|", "<", ">", ".": begin
        held_op = ch;
        scan    = stt_pkg::M_OP;
        return;
      end
      ";": k = stt_pkg::K_SEMI;
      "[": k = stt_pkg::K_LBRACK;
      "]": k = stt_pkg::K_RBRACK;
      "(": k = stt_pkg::K_LPAREN;
      ")": k = stt_pkg::K_RPAREN;
      "{": k = stt_pkg::K_LBRACE;
      "}": k = stt_pkg::K_RBRACE;
      "^": k = stt_pkg::K_CARET;
      "~": k = stt_pkg::K_TILDE;
      ",": k = stt_pkg::K_COMMA;
      "?": k = stt_pkg::K_QUEST;
      default: begin
        stop_on(stt_pkg::E_CHAR, here_line, here_col, ch);
        return;
      end
    endcase
    put(k, here_line, here_col);
  endtask

  task automatic pair_op(logic [7:0] ch);
    logic [5:0] k;
    bit         ok;
    k = stt_pkg::K_EOF;
    if (ch == "=") begin
      case (held_op)
        "=": k = stt_pkg::K_EQ;
        "!": k = stt_pkg::K_NE;
        "<": k = stt_pkg::K_LE;
        ">": k = stt_pkg::K_GE;
        "+": k = stt_pkg::K_ADDEQ;
        "-": k = stt_pkg::K_SUBEQ;
        "*": k = stt_pkg::K_MULEQ;
        "/": k = stt_pkg::K_DIVEQ;
        "%": k = stt_pkg::K_MODEQ;
        default: k = stt_pkg::K_EOF;
      endcase
    end else if (held_op == ch) begin
      case (ch)
        "&": k = stt_pkg::K_ANDAND;
        "|": k = stt_pkg::K_OROR;
        "<": k = stt_pkg::K_SHL;
        ">": k = stt_pkg::K_SHR;
        ".": k = stt_pkg::K_DOTDOT;
        default: k = stt_pkg::K_EOF;
      endcase
    end
    if (k != stt_pkg::K_EOF) begin
      put(k, tok_line, tok_col);
      scan = stt_pkg::M_IDLE;
    end else begin
      lone_op(ok);
      if (ok) start_tok(ch);
    end
  endtask

  task automatic in_string(logic [7:0] ch);
    scan = stt_pkg::M_STR;
    if (ch == 8'h22) scan = stt_pkg::M_IDLE;
    else if (ch == "\\") scan = stt_pkg::M_ESC;
    else sbyte(ch);
  endtask

  task automatic lex_byte(logic [7:0] ch);
    case (scan)
      stt_pkg::M_COMMENT: if (ch == 8'h0a) start_tok(ch);
      stt_pkg::M_IDENT: begin
        if (alpha(ch) || dig(ch) || ch == "_") grow_word(ch);
        else begin
          give_word();
          start_tok(ch);
        end
      end
      stt_pkg::M_INT: begin
        if (dig(ch)) acc_val = acc_val * 64'd10 + 64'(ch - "0");
        else if (ch == ".") begin
          dot_col = here_col;
          scan    = stt_pkg::M_INT_DOT;
        end else begin
          give_num(stt_pkg::K_INT);
          start_tok(ch);
        end
      end
      stt_pkg::M_INT_DOT: begin
        if (dig(ch)) begin
          acc_val  = acc_val * 64'd10 + 64'(ch - "0");
          frac_cnt = 8'd1;
          scan     = stt_pkg::M_FRAC;
        end else begin
          // the dot becomes a held operator starting at its own column
          give_num(stt_pkg::K_INT);
          held_op = ".";
          tok_col = dot_col;
          scan    = stt_pkg::M_OP;
          pair_op(ch);
        end
      end
      stt_pkg::M_FRAC: begin
        if (dig(ch)) begin
          acc_val = acc_val * 64'd10 + 64'(ch - "0");
          if (frac_cnt != 8'hff) frac_cnt++;
        end else begin
          give_num(stt_pkg::K_FLOAT);
          start_tok(ch);
        end
      end
      stt_pkg::M_OP:  pair_op(ch);
      stt_pkg::M_STR: in_string(ch);
      stt_pkg::M_ESC: begin
        scan = stt_pkg::M_STR;
        case (ch)
          "n": sbyte(8'h0a);
          "t": sbyte(8'h09);
          "r": sbyte(8'h0d);
          "0": sbyte(8'h00);
          "x": scan = stt_pkg::M_HEX0;
          default: sbyte(ch);
        endcase
      end
      stt_pkg::M_HEX0: begin
        if (hexc(ch)) begin
          hex_hi = ch;
          scan   = stt_pkg::M_HEX1;
        end else begin
          sbyte("x");
          in_string(ch);
        end
      end
      stt_pkg::M_HEX1: begin
        if (hexc(ch)) begin
          sbyte({nibble(hex_hi), nibble(ch)});
          scan = stt_pkg::M_STR;
        end else begin
          sbyte("x");
          sbyte(hex_hi);
          in_string(ch);
        end
      end
      default: start_tok(ch);
    endcase
  endtask

  task automatic close_source();
    bit ok;
    case (scan)
      stt_pkg::M_IDENT: give_word();
      stt_pkg::M_INT:   give_num(stt_pkg::K_INT);
      stt_pkg::M_INT_DOT: begin
        give_num(stt_pkg::K_INT);
        stop_on(stt_pkg::E_CHAR, tok_line, dot_col, ".");
      end
      stt_pkg::M_FRAC: give_num(stt_pkg::K_FLOAT);
      stt_pkg::M_OP:   lone_op(ok);
      stt_pkg::M_STR, stt_pkg::M_ESC, stt_pkg::M_HEX0, stt_pkg::M_HEX1:
        stop_on(stt_pkg::E_UNTERM, tok_line, tok_col, 8'd0);
      default: ;
    endcase
    if (!halted) put(stt_pkg::K_EOF, line_no, col_no);
  endtask

  // Works out the tokens one byte causes and queues them.
  task automatic predict_tokens(logic [7:0] ch, logic eos);
    bit was_esc;
    tok_exp_t e;
    step_n = 0;
    if (!halted && ch != 8'd0) begin
      was_esc   = (scan == stt_pkg::M_ESC);
      here_line = line_no;
      here_col  = col_no;
      here_off  = src_off;
      lex_byte(ch);
      if (src_off != 24'hffffff) src_off++;
      // an escaped newline only moves the column
      if (ch == 8'h0a && !was_esc) begin
        line_no = bump(line_no);
        col_no  = 16'd1;
      end else col_no = bump(col_no);
    end
    if (eos || ch == 8'd0) begin
      if (!halted) close_source();
      clear_lexer();
    end
    for (int i = 0; i < step_n; i++) begin
      e.t    = step_out[i];
      e.last = (i == step_n - 1);
      tokens_due.push_back(e);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
  endtask

  // Sends frag as one source: last byte flagged, or a zero byte appended.
  task automatic send_source(bit zero_end, bit rush);
    src_item_t it;
    it.rush = rush;
    foreach (frag[i]) begin
      it.b   = frag[i];
      it.eos = !zero_end && (i == frag.size() - 1);
      src_items.push_back(it);
    end
    if (zero_end) begin
      it.b   = 8'd0;
      it.eos = 1'($urandom_range(0, 1));
      src_items.push_back(it);
    end
    frag.delete();
  endtask

  task automatic add_digits(int n);
    repeat (n) frag.push_back(8'($urandom_range("0", "9")));
  endtask

  task automatic add_random_string(bit closed);
    int n;
    frag.push_back(8'h22);
    n = $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: add_text("\\x4f");
        1: begin
          frag.push_back("\\");
          frag.push_back(8'($urandom_range(1, 255)));
        end
        2: add_text("\\xA");
        default: begin
          logic [7:0] b;
          b = 8'($urandom_range(1, 255));
          if (b == 8'h22 || b == "\\") b = "q";
          frag.push_back(b);
        end
      endcase
    end
    if (closed) frag.push_back(8'h22);
  endtask

  task automatic add_random_piece();
    string ops[26] = '{"+", "-", "*", "/", "%", "=", "!", "&", "|", "<", ">", "+=", "-=",
                       "*=", "/=", "%=", "==", "!=", "<=", ">=", "&&", "||", "<<", ">>",
                       "..", "."};
    string punct = ";[](){}^~,?";
    case ($urandom_range(0, 13))
      0: begin
        frag.push_back($urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : "_");
        repeat ($urandom_range(0, 5))
          case ($urandom_range(0, 3))
            0: frag.push_back(8'($urandom_range("A", "Z")));
            1: frag.push_back(8'($urandom_range("0", "9")));
            default: frag.push_back(8'($urandom_range("a", "z")));
          endcase
      end
      1: add_text(kw_list[$urandom_range(0, 14)]);
      2: add_digits($urandom_range(1, 22));
      3: begin
        add_digits($urandom_range(1, 4));
        frag.push_back(".");
        add_digits($urandom_range(1, 4));
      end
      4, 5: add_text(ops[$urandom_range(0, 25)]);
      6: add_random_string(1'b1);
      7: frag.push_back(8'h0a);
      8: add_text("# note <\n");
      9: frag.push_back($urandom_range(0, 1) ? 8'h09 : 8'h0d);
      10: frag.push_back(punct[$urandom_range(0, punct.len() - 1)]);
      11: add_text("<");
      12: add_text(";");
      default: frag.push_back(8'($urandom_range(1, 255)));
    endcase
  endtask

  initial begin
    int rnd_bytes;
    clear_lexer();
    // Directed: block open, keywords, operators and punctuation (operators with no gaps).
    add_text("<a;<b\n<c<d");
    send_source(1'b0, 1'b0);
    add_text("if nil ifx _Z9");
    send_source(1'b0, 1'b0);
    add_text("+=<<..&&!x|^~,?[](){}>");
    send_source(1'b0, 1'b1);
    // Numbers: lone dot after digits, range after digits, decimals.
    add_text("1.x");
    send_source(1'b0, 1'b0);
    add_text("1..2 3.14 7.");
    send_source(1'b0, 1'b0);
    // Strings: all escapes, good and broken hex escapes, escaped newline.
    add_text("\"a\\n\\t\\r\\\\\\\"\\0\\q\\x41\\xZ\\x4G\\\nb\"\n\"c\\x");
    send_source(1'b0, 1'b0);
    add_text("x#c\n@");
    send_source(1'b0, 1'b0);
    frag.push_back(8'hc8);
    add_text("ab");
    send_source(1'b1, 1'b0);
    add_text("\"o\\");
    send_source(1'b0, 1'b0);
    frag.push_back(8'hff);
    send_source(1'b0, 1'b0);
    send_source(1'b1, 1'b0);

    // Random sources: mostly well formed, some noise and open strings.
    rnd_bytes = 0;
    while (rnd_bytes < 12) begin
      repeat ($urandom_range(1, 4)) begin
        add_random_piece();
        if ($urandom_range(0, 3) != 0) frag.push_back(" ");
      end
      if ($urandom_range(0, 7) == 0) add_random_string(1'b0);
      rnd_bytes += frag.size();
      send_source($urandom_range(0, 4) == 0, 1'b0);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Byte driver: changes at the falling edge, one item per transaction
  // --------------------------------------------------------------------------
  int unsigned in_gap = 0;
  int unsigned in_burst = 0;
  initial begin
    byte_ch.valid         = 1'b0;
    byte_ch.source_byte   = '0;
    byte_ch.end_of_source = 1'b0;
    tok_ch.ready          = 1'b0;
  end

  always @(negedge clk_i) begin
    logic      nv;
    src_item_t it;
    if (rst_ni) begin
      nv = byte_ch.valid;
      if (nv && took_byte) nv = 1'b0;
      if (!nv) begin
        if (in_gap > 0) in_gap--;
        else if (src_items.size() > 0) begin
          it = src_items.pop_front();
          byte_ch.source_byte   <= it.b;
          byte_ch.end_of_source <= it.eos;
          nv = 1'b1;
          // stretches with no gaps now and then
          if (in_burst > 0) in_burst--;
          else if ($urandom_range(0, 40) == 0) in_burst = $urandom_range(10, 40);
          in_gap = (it.rush || in_burst > 0) ? 0 : $urandom_range(0, 12);
        end
      end
      byte_ch.valid <= nv;
    end
  end

  // Token side stall pattern, drawn per token taken.
  int unsigned out_stall = 0;
  int unsigned out_burst = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took_tok) begin
        if (out_burst > 0) out_burst--;
        else if ($urandom_range(0, 40) == 0) out_burst = $urandom_range(10, 40);
        out_stall = (out_burst > 0) ? 0 : $urandom_range(0, 12);
      end
      if (out_stall > 0) begin
        out_stall--;
        tok_ch.ready <= 1'b0;
      end else tok_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and checker: compare then predict, both at the rising edge
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: token %0d field %s mismatch: expected %0h, actual %0h",
               $time, toks_seen, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tok_exp_t e;
    if (!rst_ni) begin
      clear_lexer();
      took_byte <= 1'b0;
      took_tok  <= 1'b0;
    end else begin
      took_tok <= tok_ch.valid && tok_ch.ready;
      if (tok_ch.valid && tok_ch.ready) begin
        toks_seen++;
        if (tokens_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected token: expected none, actual kind %0d", $time,
                   tok_ch.lexeme_kind);
        end else begin
          e = tokens_due.pop_front();
          check_field("lexeme_kind", 64'(e.t.kind), 64'(tok_ch.lexeme_kind));
          check_field("token_line", 64'(e.t.line), 64'(tok_ch.token_line));
          check_field("token_column", 64'(e.t.col), 64'(tok_ch.token_column));
          check_field("number_value", e.t.num, tok_ch.number_value);
          check_field("fraction_digits", 64'(e.t.frac), 64'(tok_ch.fraction_digits));
          check_field("string_char", 64'(e.t.schar), 64'(tok_ch.string_char));
          check_field("span_offset", 64'(e.t.off), 64'(tok_ch.span_offset));
          check_field("span_length", 64'(e.t.len), 64'(tok_ch.span_length));
          check_field("error_code", 64'(e.t.err), 64'(tok_ch.error_code));
          check_field("last_of_step", 64'(e.last), 64'(tok_ch.last_of_step));
        end
      end
      took_byte <= byte_ch.valid && byte_ch.ready;
      if (byte_ch.valid && byte_ch.ready) begin
        bytes_taken++;
        predict_tokens(byte_ch.source_byte, byte_ch.end_of_source);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog and end of run
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d tokens still due", $time, tokens_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    while (src_items.size() > 0 || byte_ch.valid || tokens_due.size() > 0)
      @(posedge clk_i);
    // late extra tokens would show up here
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Run covered %0d source bytes and %0d tokens in %0d cycles.",
             bytes_taken, toks_seen, cycles);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
